@@ hw/rtl/half_float_reinhard_tonemap_macros.svh @@
// Assertion macros for the tonemap pipeline.
// Included by modules that check their own stage behavior.
`ifndef HALF_FLOAT_REINHARD_TONEMAP_MACROS_SVH
`define HALF_FLOAT_REINHARD_TONEMAP_MACROS_SVH

// Same-cycle implication, idle during reset.
`define RTM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset.
`define RTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rtm_pkg.sv @@
// Package for the half float Reinhard tonemap: types and the threshold table.
// No dependencies; the table is built at elaboration.
`timescale 1ns / 1ps
package rtm_pkg;

   localparam int unsigned CHANNELS  = 3;
   localparam int unsigned H_WIDTH   = 15;
   localparam int unsigned K_WIDTH   = 8;
   localparam int unsigned K_COUNT   = 256;
   localparam logic [4:0]  EXP_ONES  = 5'h1F;
   localparam int unsigned H_NONE    = 32'h7C00;

   typedef logic [CHANNELS-1:0][H_WIDTH-1:0] mag_vec_type;
   typedef logic [CHANNELS-1:0][K_WIDTH-1:0] code_vec_type;
   typedef logic [K_COUNT-1:0][H_WIDTH-1:0]  thr_table_type;

   // true when (k/255)^2.2 <= v/(1+v) for the positive half pattern h
   function automatic logic tone_holds(int unsigned k, int unsigned h);
      logic [255:0] lhs;
      logic [255:0] rhs;
      int unsigned  ex;
      int unsigned  fr;
      int unsigned  m;
      int           e;
      longint unsigned a;
      longint unsigned b;
      ex = (h >> 10) & 32'h1F;
      fr = h & 32'h3FF;
      if (ex == 0) begin
         m = fr;
         e = -24;
      end else begin
         m = fr | 32'h400;
         e = int'(ex) - 25;
      end
      if (m == 0) begin
         return (k == 0);
      end
      if (e >= 0) begin
         a = longint'(m) << e;
         b = 1;
      end else begin
         a = m;
         b = longint'(1) << (-e);
      end
      rhs = 256'd1;
      lhs = 256'd1;
      for (int i = 0; i < 11; i++) begin
         rhs = rhs * 256'd255;
         lhs = lhs * 256'(k);
      end
      for (int i = 0; i < 5; i++) begin
         rhs = rhs * 256'(a);
         lhs = lhs * 256'(a + b);
      end
      return (lhs <= rhs);
   endfunction

   // smallest positive finite pattern that reaches code k (7C00 when none does)
   function automatic thr_table_type build_thresholds();
      thr_table_type t;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   mid;
      t = '0;
      for (int unsigned k = 1; k < K_COUNT; k++) begin
         lo = 1;
         hi = H_NONE;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (tone_holds(k, mid)) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         t[k] = lo[H_WIDTH-1:0];
      end
      return t;
   endfunction

   localparam thr_table_type RTM_THR = build_thresholds();

endpackage

@@ hw/rtl/rtm_stage.sv @@
// One binary search step of the tonemap pipeline, three channels wide.
// Depends on rtm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "half_float_reinhard_tonemap_macros.svh"
module rtm_stage #(
   parameter int unsigned STEP_BIT = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rtm_pkg::mag_vec_type  in_h,
   input  rtm_pkg::code_vec_type in_k,
   output logic                 out_valid,
   output rtm_pkg::mag_vec_type  out_h,
   output rtm_pkg::code_vec_type out_k
);
   import rtm_pkg::*;

   logic         valid_ff;
   mag_vec_type  h_ff;
   code_vec_type k_ff;
   code_vec_type k_in;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic [K_WIDTH-1:0] cand;
         cand = in_k[c] | K_WIDTH'(1 << STEP_BIT);
         k_in[c] = (RTM_THR[cand] <= in_h[c]) ? cand : in_k[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff <= in_h;
         k_ff <= k_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_h     = h_ff;
   assign out_k     = k_ff;

   `RTM_ASSERT_NEXT(a_hold, !en, $stable(k_ff) && $stable(valid_ff), "stalled stage changed")
   `RTM_ASSERT_NEXT(a_move, en, valid_ff == $past(in_valid), "valid bit lost in stage")
   `RTM_ASSERT_IMP(a_thr, valid_ff, RTM_THR[k_ff[0]] <= h_ff[0], "code above its threshold")

endmodule

@@ hw/rtl/half_float_reinhard_tonemap.sv @@
// Half float Reinhard tonemap with gamma 2.2, three channels per pixel.
// Depends on rtm_pkg and rtm_stage.
//
// Use: req_valid/req_ready take one pixel word of three binary16 channels;
// rsp_valid/rsp_ready deliver three 8-bit channels, floor(255*(v/(1+v))^(1/2.2)).
// Negative, infinite and NaN channels give 0.
// Structure: one input register, then one register per bit of the 8-bit code,
// found by binary search over a 256-entry threshold table built at elaboration.
// Throughput: one pixel per clock while rsp_ready is high.
// Reset clears every valid bit; no pixel is in flight afterwards.
// When the receiver holds rsp_ready low while rsp_valid is high, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated. Bubbles
// advance when the output register is empty.
`timescale 1ns / 1ps
module half_float_reinhard_tonemap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_red_half,
   input  logic [15:0] req_green_half,
   input  logic [15:0] req_blue_half,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out
);
   import rtm_pkg::*;

   logic        en;
   logic        valid_ff;
   mag_vec_type h_ff;
   mag_vec_type h_in;
   logic [15:0] raw [CHANNELS];

   logic         sv_valid [K_WIDTH+1];
   mag_vec_type  sv_h     [K_WIDTH+1];
   code_vec_type sv_k     [K_WIDTH+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign raw[0] = req_red_half;
   assign raw[1] = req_green_half;
   assign raw[2] = req_blue_half;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (raw[c][15] || (raw[c][14:10] == EXP_ONES)) begin
            h_in[c] = '0;
         end else begin
            h_in[c] = raw[c][H_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff <= h_in;
      end
   end

   assign sv_valid[0] = valid_ff;
   assign sv_h[0]     = h_ff;
   assign sv_k[0]     = '0;

   for (genvar s = 0; s < K_WIDTH; s++) begin : g_step
      rtm_stage #(.STEP_BIT(K_WIDTH - 1 - s)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sv_valid[s]),
         .in_h      (sv_h[s]),
         .in_k      (sv_k[s]),
         .out_valid (sv_valid[s+1]),
         .out_h     (sv_h[s+1]),
         .out_k     (sv_k[s+1])
      );
   end

   assign rsp_valid     = sv_valid[K_WIDTH];
   assign rsp_red_out   = sv_k[K_WIDTH][0];
   assign rsp_green_out = sv_k[K_WIDTH][1];
   assign rsp_blue_out  = sv_k[K_WIDTH][2];

endmodule
